FILE: sv/crhp_pkg.sv
// Shared types and constants for the chunk reply header parser.
// No dependencies; compiled first.
package crhp_pkg;

   localparam int OUT_W      = 32;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int MARK_LEN   = 9;

   localparam logic [7:0] CH_ERR     = 8'h45;  // 'E'
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;

   typedef enum logic [2:0] {
      PH_FIRST,
      PH_OFF,
      PH_LEN,
      PH_AFTER,
      PH_MARK,
      PH_SKIP,
      PH_PAY,
      PH_DROP
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_ERROR,
      ST_CUT,
      ST_MARKER
   } status_type;

   typedef struct packed {
      logic               has_pay;
      logic [7:0]         pay_byte;
      logic               has_sum;
      logic [OUT_W-1:0]   offset;
      logic [OUT_W-1:0]   length;
      logic               squished;
      status_type         status;
      logic [OUT_W-1:0]   count;
   } entry_type;

   // "Squished\n"
   function automatic logic [7:0] marker_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h53;
         4'd1:    ch = 8'h71;
         4'd2:    ch = 8'h75;
         4'd3:    ch = 8'h69;
         4'd4:    ch = 8'h73;
         4'd5:    ch = 8'h68;
         4'd6:    ch = 8'h65;
         4'd7:    ch = 8'h64;
         4'd8:    ch = 8'h0a;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: sv/crhp_if.sv
// Handshake interfaces for the parser's byte input and result output.
// Depends on nothing.
interface crhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_datagram;

   modport source (output valid, output in_byte, output end_of_datagram, input ready);
   modport sink   (input valid, input in_byte, input end_of_datagram, output ready);
endinterface

interface crhp_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  payload_byte;
   logic [31:0] chunk_offset;
   logic [31:0] chunk_length;
   logic        squished;
   logic [1:0]  parse_status;
   logic [31:0] payload_count;
   logic        last;

   modport source (output valid, output kind, output payload_byte, output chunk_offset,
                   output chunk_length, output squished, output parse_status,
                   output payload_count, output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input chunk_offset,
                   input chunk_length, input squished, input parse_status,
                   input payload_count, input last, output ready);
endinterface

FILE: sv/chunk_reply_header_parser.sv
// Chunk reply header parser: one datagram byte per word in, payload and summary words out.
// Depends on crhp_pkg and the interfaces in crhp_if.sv.
//
// req_ch carries one datagram byte per word, end_of_datagram on its final byte.
// rsp_ch carries a payload word (kind 0) for each payload byte within the
// parsed length, and a summary word (kind 1, last 1) after the final byte with
// offset, length, squished flag, payload count and status.
// An accepted byte is registered, run through the header state update and, if it
// yields a word, written to a four-entry result queue, from which its first result
// is offered. One byte is taken every cycle while the queue holds at most two
// entries. A final byte that also carries payload yields two words on rsp_ch.
// When rsp_ch stalls the queue fills and req_ch.ready drops; nothing is lost.
// Synchronous reset empties the queue and returns the parser to the start of a
// datagram. After each summary the parser is back at the start as well.
module chunk_reply_header_parser import crhp_pkg::*; #(
   parameter int NUMBER_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   crhp_req_if.sink   req_ch,
   crhp_rsp_if.source rsp_ch
);

   logic                   stage_valid_ff;
   logic [7:0]             stage_byte_ff;
   logic                   stage_end_ff;

   phase_type              phase_ff, phase_in, phase_next;
   logic [NUMBER_BITS-1:0] offset_ff, offset_in;
   logic [NUMBER_BITS-1:0] length_ff, length_in;
   logic [NUMBER_BITS-1:0] bytes_ff, bytes_in;
   logic [3:0]             marker_pos_ff, marker_pos_in;
   logic                   squished_ff, squished_in;
   status_type             status_ff, status_in;

   logic                   is_digit;
   logic [NUMBER_BITS-1:0] digit;
   logic [NUMBER_BITS-1:0] offset_push, length_push;
   logic                   marker_hit;
   logic                   pay_hit;
   status_type             status_step, status_sum;
   entry_type              entry;
   logic                   push;

   entry_type              fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   pay_sent_ff;
   entry_type              head;
   logic                   show_pay;
   logic                   pop;

   assign req_ch.ready = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_ch.valid && req_ch.ready;
      end
      if (req_ch.valid && req_ch.ready) begin
         stage_byte_ff <= req_ch.in_byte;
         stage_end_ff  <= req_ch.end_of_datagram;
      end
   end

   assign is_digit    = (stage_byte_ff >= CH_ZERO) && (stage_byte_ff <= CH_NINE);
   assign digit       = NUMBER_BITS'(stage_byte_ff - CH_ZERO);
   assign offset_push = (offset_ff << 3) + (offset_ff << 1) + digit;
   assign length_push = (length_ff << 3) + (length_ff << 1) + digit;
   assign marker_hit  = (marker_pos_ff < 4'(MARK_LEN))
                        && (stage_byte_ff == marker_char(marker_pos_ff));
   assign pay_hit     = (phase_ff == PH_PAY) && (bytes_ff < length_ff);

   // next phase for the byte alone
   always_comb begin
      phase_next = phase_ff;
      unique case (phase_ff)
         PH_FIRST: begin
            if (stage_byte_ff == CH_ERR) phase_next = PH_DROP;
            else if (stage_byte_ff == CH_NEWLINE) phase_next = PH_LEN;
            else phase_next = PH_OFF;
         end
         PH_OFF: begin
            if (stage_byte_ff == CH_NEWLINE) phase_next = PH_LEN;
         end
         PH_LEN: begin
            if (stage_byte_ff == CH_NEWLINE) phase_next = PH_AFTER;
         end
         PH_AFTER: begin
            if (stage_byte_ff == marker_char(4'd0)) phase_next = PH_MARK;
            else phase_next = PH_PAY;
         end
         PH_MARK: begin
            if (!marker_hit) phase_next = PH_DROP;
            else if (marker_pos_ff == 4'(MARK_LEN - 1)) phase_next = PH_SKIP;
         end
         PH_SKIP: phase_next = PH_PAY;
         PH_PAY:  phase_next = PH_PAY;
         PH_DROP: phase_next = PH_DROP;
         default: phase_next = PH_DROP;
      endcase
      if (!stage_valid_ff) phase_in = phase_ff;
      else if (stage_end_ff) phase_in = PH_FIRST;
      else phase_in = phase_next;
   end

   // data state and result words
   always_comb begin
      offset_in     = offset_ff;
      length_in     = length_ff;
      bytes_in      = bytes_ff;
      marker_pos_in = marker_pos_ff;
      squished_in   = squished_ff;
      status_step   = status_ff;

      case (phase_ff)
         PH_FIRST: begin
            if (stage_byte_ff == CH_ERR) status_step = ST_ERROR;
            else if (stage_byte_ff != CH_NEWLINE && is_digit) offset_in = offset_push;
         end
         PH_OFF: begin
            if (stage_byte_ff != CH_NEWLINE && is_digit) offset_in = offset_push;
         end
         PH_LEN: begin
            if (stage_byte_ff != CH_NEWLINE && is_digit) length_in = length_push;
         end
         PH_AFTER: begin
            if (stage_byte_ff == marker_char(4'd0)) marker_pos_in = 4'd1;
         end
         PH_MARK: begin
            if (marker_hit) begin
               marker_pos_in = marker_pos_ff + 4'd1;
               if (marker_pos_ff == 4'(MARK_LEN - 1)) squished_in = 1'b1;
            end else begin
               status_step = ST_MARKER;
            end
         end
         PH_PAY: begin
            if (pay_hit) bytes_in = bytes_ff + NUMBER_BITS'(1);
         end
         default: ;
      endcase

      status_sum = status_step;
      if (status_step == ST_OK) begin
         case (phase_next)
            PH_FIRST, PH_OFF, PH_LEN: status_sum = ST_CUT;
            PH_AFTER, PH_MARK:        status_sum = ST_MARKER;
            default:                  status_sum = ST_OK;
         endcase
      end

      entry.has_pay  = pay_hit;
      entry.pay_byte = stage_byte_ff;
      entry.has_sum  = stage_end_ff;
      entry.status   = status_sum;
      if (status_sum == ST_ERROR) begin
         entry.offset   = '0;
         entry.length   = '0;
         entry.squished = 1'b0;
         entry.count    = '0;
      end else begin
         entry.offset   = OUT_W'(offset_in);
         entry.length   = OUT_W'(length_in);
         entry.squished = squished_in;
         entry.count    = OUT_W'(bytes_in);
      end

      status_in = status_step;
      if (!stage_valid_ff) begin
         offset_in     = offset_ff;
         length_in     = length_ff;
         bytes_in      = bytes_ff;
         marker_pos_in = marker_pos_ff;
         squished_in   = squished_ff;
         status_in     = status_ff;
      end else if (stage_end_ff) begin
         offset_in     = '0;
         length_in     = '0;
         bytes_in      = '0;
         marker_pos_in = 4'd0;
         squished_in   = 1'b0;
         status_in     = ST_OK;
      end
   end

   assign push = stage_valid_ff && (pay_hit || stage_end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_FIRST;
         offset_ff     <= '0;
         length_ff     <= '0;
         bytes_ff      <= '0;
         marker_pos_ff <= 4'd0;
         squished_ff   <= 1'b0;
         status_ff     <= ST_OK;
      end else begin
         phase_ff      <= phase_in;
         offset_ff     <= offset_in;
         length_ff     <= length_in;
         bytes_ff      <= bytes_in;
         marker_pos_ff <= marker_pos_in;
         squished_ff   <= squished_in;
         status_ff     <= status_in;
      end
   end

   // result queue; one entry per pushed byte, payload word goes out before its summary
   assign head     = fifo_ff[rd_ptr_ff];
   assign show_pay = head.has_pay && !pay_sent_ff;
   assign pop      = rsp_ch.valid && rsp_ch.ready && (!show_pay || !head.has_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         pay_sent_ff <= 1'b0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
         if (pop) pay_sent_ff <= 1'b0;
         else if (rsp_ch.valid && rsp_ch.ready && show_pay) pay_sent_ff <= 1'b1;
      end
      if (push) fifo_ff[wr_ptr_ff] <= entry;
   end

   always_comb begin
      rsp_ch.valid = (count_ff != '0);
      if (show_pay) begin
         rsp_ch.kind          = 1'b0;
         rsp_ch.payload_byte  = head.pay_byte;
         rsp_ch.chunk_offset  = '0;
         rsp_ch.chunk_length  = '0;
         rsp_ch.squished      = 1'b0;
         rsp_ch.parse_status  = ST_OK;
         rsp_ch.payload_count = '0;
         rsp_ch.last          = 1'b0;
      end else begin
         rsp_ch.kind          = 1'b1;
         rsp_ch.payload_byte  = 8'h00;
         rsp_ch.chunk_offset  = head.offset;
         rsp_ch.chunk_length  = head.length;
         rsp_ch.squished      = head.squished;
         rsp_ch.parse_status  = head.status;
         rsp_ch.payload_count = head.count;
         rsp_ch.last          = 1'b1;
      end
   end

endmodule

FILE: sv/crhp_checker.sv
// Port-level checks for the chunk reply header parser, bound to the top level.
// Depends on crhp_pkg and chunk_reply_header_parser.
module crhp_checker import crhp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        kind,
   input logic        last,
   input logic        squished,
   input logic [1:0]  parse_status,
   input logic [31:0] chunk_offset,
   input logic [31:0] chunk_length,
   input logic [31:0] payload_count
);

   // summary words close a datagram, payload words never do
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (kind == last))
      else $error("last does not match word kind");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind && parse_status == ST_ERROR) |->
         (chunk_offset == '0 && chunk_length == '0 && payload_count == '0 && !squished))
      else $error("error reply summary carries header data");

   a_cut_no_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && kind && parse_status == ST_CUT) |-> (payload_count == '0 && !squished))
      else $error("cut-short summary reports payload or marker");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind chunk_reply_header_parser crhp_checker u_crhp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .kind          (rsp_ch.kind),
   .last          (rsp_ch.last),
   .squished      (rsp_ch.squished),
   .parse_status  (rsp_ch.parse_status),
   .chunk_offset  (rsp_ch.chunk_offset),
   .chunk_length  (rsp_ch.chunk_length),
   .payload_count (rsp_ch.payload_count)
);

FILE: tb/sv/reply_parse_checker.sv
`timescale 1ns / 1ps
// Checker for the chunk reply header parser: watches the byte and result channels,
// predicts the words each accepted byte causes and compares them in order.
// Depends on crhp_pkg and the interfaces in crhp_if.sv.
module reply_parse_checker import crhp_pkg::*; #(
   parameter int NUMBER_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   crhp_req_if  req_mon,
   crhp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_words
);

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;
   localparam logic [8*MARK_LEN-1:0] SQUISH_TEXT = "Squished\n";

   typedef struct {
      logic        kind;
      logic [7:0]  data;
      logic [31:0] offset;
      logic [31:0] length;
      logic        squished;
      status_type  status;
      logic [31:0] count;
      logic        last;
   } reply_word_type;

   reply_word_type         expected_words[$];
   phase_type              phase_q;
   logic [NUMBER_BITS-1:0] offset_q;
   logic [NUMBER_BITS-1:0] length_q;
   logic [3:0]             mark_pos;
   logic                   squish_q;
   logic [NUMBER_BITS-1:0] sent_q;
   status_type             status_q;
   int                     mismatch_total = 0;

   function automatic logic [7:0] squish_char(input logic [3:0] pos);
      return SQUISH_TEXT[8*(MARK_LEN-1-int'(pos)) +: 8];
   endfunction

   function automatic logic [NUMBER_BITS-1:0] push_digit(input logic [NUMBER_BITS-1:0] acc,
                                                         input logic [7:0] b);
      if (b >= CH_ZERO && b <= CH_NINE)
         return NUMBER_BITS'(acc * 10 + (b - CH_ZERO));
      return acc;
   endfunction

   function automatic void clear_parse();
      phase_q  = PH_FIRST;
      offset_q = '0;
      length_q = '0;
      mark_pos = '0;
      squish_q = 1'b0;
      sent_q   = '0;
      status_q = ST_OK;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic eod);
      reply_word_type w;
      case (phase_q)
         PH_FIRST: begin
            if (b == CH_ERR) begin
               status_q = ST_ERROR;
               phase_q  = PH_DROP;
            end else if (b == CH_NEWLINE) begin
               phase_q = PH_LEN;
            end else begin
               offset_q = push_digit(offset_q, b);
               phase_q  = PH_OFF;
            end
         end
         PH_OFF: begin
            if (b == CH_NEWLINE) phase_q = PH_LEN;
            else offset_q = push_digit(offset_q, b);
         end
         PH_LEN: begin
            if (b == CH_NEWLINE) phase_q = PH_AFTER;
            else length_q = push_digit(length_q, b);
         end
         PH_AFTER: begin
            if (b == squish_char(4'd0)) begin
               mark_pos = 4'd1;
               phase_q  = PH_MARK;
            end else begin
               phase_q = PH_PAY;
            end
         end
         PH_MARK: begin
            if (b == squish_char(mark_pos)) begin
               mark_pos++;
               if (mark_pos == MARK_LEN) begin
                  squish_q = 1'b1;
                  phase_q  = PH_SKIP;
               end
            end else begin
               status_q = ST_MARKER;
               phase_q  = PH_DROP;
            end
         end
         PH_SKIP: phase_q = PH_PAY;
         PH_PAY: begin
            if (sent_q < length_q) begin
               sent_q++;
               w = '{KIND_PAYLOAD, b, 32'd0, 32'd0, 1'b0, ST_OK, 32'd0, 1'b0};
               expected_words.push_back(w);
            end
         end
         default: ;
      endcase

      if (eod) begin
         if (status_q == ST_OK) begin
            if (phase_q == PH_FIRST || phase_q == PH_OFF || phase_q == PH_LEN)
               status_q = ST_CUT;
            else if (phase_q == PH_AFTER || phase_q == PH_MARK)
               status_q = ST_MARKER;
         end
         if (status_q == ST_ERROR)
            w = '{KIND_SUMMARY, 8'd0, 32'd0, 32'd0, 1'b0, ST_ERROR, 32'd0, 1'b1};
         else
            w = '{KIND_SUMMARY, 8'd0, 32'(offset_q), 32'(length_q), squish_q, status_q,
                  32'(sent_q), 1'b1};
         expected_words.push_back(w);
         clear_parse();
      end
   endfunction

   function automatic string show_word(input reply_word_type w);
      return $sformatf({"kind %0d byte %02h offset %0d length %0d squished %0d",
                        " status %0d count %0d last %0d"},
                       w.kind, w.data, w.offset, w.length, w.squished, w.status, w.count,
                       w.last);
   endfunction

   always @(posedge clock) begin : monitor
      reply_word_type got;
      reply_word_type want;
      if (reset) begin
         expected_words.delete();
         clear_parse();
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            got = '{rsp_mon.kind, rsp_mon.payload_byte, rsp_mon.chunk_offset,
                    rsp_mon.chunk_length, rsp_mon.squished,
                    status_type'(rsp_mon.parse_status), rsp_mon.payload_count, rsp_mon.last};
            if (expected_words.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("%0t: unexpected word: %s", $realtime, show_word(got));
            end else begin
               want = expected_words.pop_front();
               if (got.kind !== want.kind || got.data !== want.data ||
                   got.offset !== want.offset || got.length !== want.length ||
                   got.squished !== want.squished || got.status !== want.status ||
                   got.count !== want.count || got.last !== want.last) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $display("%0t: word mismatch", $realtime);
                     $display("   expected %s", show_word(want));
                     $display("   actual   %s", show_word(got));
                  end
               end
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            predict_byte(req_mon.in_byte, req_mon.end_of_datagram);
      end
      fail_count    <= mismatch_total;
      pending_words <= expected_words.size();
   end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the chunk reply header parser: clock, reset, datagram stimulus,
// result back-pressure and the verdict. Depends on crhp_pkg, crhp_if.sv, the parser
// and reply_parse_checker.
module tb;
   import crhp_pkg::*;

   localparam int ITEM_TARGET  = 2000;
   localparam int LONG_HOLD    = 60;
   localparam int DRAIN_CYCLES = 16;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   bit         hold_request = 1'b0;
   bit         no_gaps = 1'b0;
   int         fail_count;
   int         pending_words;
   int         bytes_counted = 0;
   string      marker_text = "Squished\n";
   logic [7:0] dgram[$];

   crhp_req_if req_ch();
   crhp_rsp_if rsp_ch();

   chunk_reply_header_parser #(.NUMBER_BITS(32)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   reply_parse_checker #(.NUMBER_BITS(32)) parse_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // neither a digit nor a newline
   function automatic logic [7:0] junk_byte();
      logic [7:0] b;
      do b = any_byte(); while (b == CH_NEWLINE || (b >= CH_ZERO && b <= CH_NINE));
      return b;
   endfunction

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) dgram.push_back(s[i]);
   endfunction

   function automatic void add_number(input int unsigned value, input bit noisy);
      string s;
      s = $sformatf("%0d", value);
      for (int i = 0; i < s.len(); i++) begin
         if (noisy && $urandom_range(0, 3) == 0) dgram.push_back(junk_byte());
         dgram.push_back(s[i]);
      end
      if (noisy && $urandom_range(0, 1) == 0) dgram.push_back(junk_byte());
      dgram.push_back(CH_NEWLINE);
   endfunction

   function automatic void add_long_number(input int digits);
      repeat (digits) dgram.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      dgram.push_back(CH_NEWLINE);
   endfunction

   function automatic void add_header(output int unsigned len);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) dgram.push_back(CH_NEWLINE);
      else if (r == 1) add_long_number($urandom_range(10, 22));
      else add_number($urandom(), r == 2);
      r = $urandom_range(0, 19);
      if (r == 0) begin
         len = 0;
         dgram.push_back(CH_NEWLINE);
      end else if (r == 1) begin
         len = 8;
         add_long_number(20);
      end else begin
         len = $urandom_range(0, 12);
         add_number(len, r < 5);
      end
   endfunction

   function automatic void build_reply();
      int unsigned len;
      logic [7:0]  b;
      add_header(len);
      if ($urandom_range(0, 4) < 2) begin
         add_text(marker_text);
         dgram.push_back(any_byte());
      end else begin
         do b = any_byte(); while (b == marker_text[0]);
         dgram.push_back(b);
      end
      repeat ($urandom_range(0, len + 4)) dgram.push_back(any_byte());
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic eod);
      int gap;
      req_ch.valid           <= 1'b1;
      req_ch.in_byte         <= b;
      req_ch.end_of_datagram <= eod;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_datagram(input bit counted);
      int n;
      n = dgram.size();
      for (int i = 0; i < n; i++) send_byte(dgram[i], i == n - 1);
      if (counted) bytes_counted += n;
      dgram.delete();
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending_words == 0);
   endtask

   initial begin : result_pacing
      int burst;
      int gap;
      rsp_ch.ready = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 8);
            rsp_ch.ready <= 1'b1;
            repeat (burst) @(posedge clock);
            gap = pick_gap();
            if (gap > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int          r;
      int          k;
      int          dg_count;
      int unsigned len;
      logic [7:0]  b;
      req_ch.valid           = 1'b0;
      req_ch.in_byte         = 8'h00;
      req_ch.end_of_datagram = 1'b0;
      dg_count               = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // error reply, cut header, broken marker, payload beyond length, full marker
      dgram.push_back(CH_ERR);
      send_datagram(1'b1);
      dgram.push_back(CH_NEWLINE);
      send_datagram(1'b1);
      add_text("\n\nSqx");
      send_datagram(1'b1);
      add_text("9\n1\n");
      dgram.push_back(8'h00);
      dgram.push_back(8'hff);
      dgram.push_back(8'h41);
      send_datagram(1'b1);
      add_text("\n\nSquished\nz");
      send_datagram(1'b1);
      wait_drained();

      while (bytes_counted < ITEM_TARGET) begin
         dg_count++;
         if (dg_count % 40 == 0) wait_drained();
         if (dg_count % 150 == 10) begin
            // receiver stalls long while a long reply streams in back to back
            hold_request = 1'b1;
            no_gaps      = 1'b1;
            add_text("\n64\n");
            dgram.push_back(junk_byte());
            repeat (40) dgram.push_back(any_byte());
            send_datagram(1'b1);
            no_gaps = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               build_reply();
               send_datagram(1'b1);
            end else if (r < 65) begin
               build_reply();
               k = $urandom_range(1, dgram.size());
               while (dgram.size() > k) void'(dgram.pop_back());
               send_datagram(1'b1);
            end else if (r < 73) begin
               dgram.push_back(CH_ERR);
               repeat ($urandom_range(0, 6)) dgram.push_back(any_byte());
               send_datagram(1'b0);
            end else if (r < 85) begin
               add_header(len);
               k = $urandom_range(1, 8);
               for (int i = 0; i < k; i++) dgram.push_back(marker_text[i]);
               if ($urandom_range(0, 1) == 0) begin
                  do b = any_byte(); while (b == marker_text[k]);
                  dgram.push_back(b);
                  repeat ($urandom_range(0, 3)) dgram.push_back(any_byte());
               end
               send_datagram(1'b1);
            end else begin
               repeat ($urandom_range(1, 12)) dgram.push_back(any_byte());
               send_datagram(1'b1);
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: chunk_reply_header_parser.f
sv/crhp_pkg.sv
sv/crhp_if.sv
sv/chunk_reply_header_parser.sv
sv/crhp_checker.sv
tb/sv/reply_parse_checker.sv
tb/sv/tb.sv
